### design/b2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_pkg: shared types and constants
// Codes, command/status structs and the digit-to-ASCII function used by the
// number formatter controller and datapath.
// ----------------------------------------------------------------------------
package b2a_pkg;

	localparam int NUM_W   = 64;	// width of the number field
	localparam int NUM_BCD = 20;	// BCD digits, enough for 64 bits
	localparam int CNT_W   = 5;		// digit counter width
	localparam int CHAR_W  = 7;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] ASCII_X    = 7'h78;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,	// double-dabble shift steps
		ST_SKIP,	// drop leading zero digits
		ST_PFX0,	// hex prefix '0'
		ST_PFX1,	// hex prefix 'x'
		ST_EMIT		// digit output
	} state_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_X,
		SEL_DIGIT
	} char_sel_t;

	typedef struct packed {
		logic      load;	// take a new request
		logic      dabble;	// one shift-and-add-3 step
		logic      shift;	// advance to next digit
		logic      emit;	// write output register
		char_sel_t sel;
		logic      last;
	} cmd_t;

	typedef struct packed {
		logic bits_done;	// final conversion step pending
		logic digits_last;	// one digit left
		logic top_zero;		// current top BCD digit is zero
		logic out_free;		// output register can take a character
	} sts_t;

	// "0123456789abcdef"
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] c;
		if (nib < 4'hA) begin
			c = ASCII_ZERO + {3'b000, nib};
		end else begin
			c = 7'h61 + {3'b000, nib - 4'hA};
		end
		return c;
	endfunction

endpackage

### design/b2a_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_dp: formatter datapath
// Value shift register, BCD digit chain, step counters and the output
// character register.
// ----------------------------------------------------------------------------
module b2a_dp import b2a_pkg::*; #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              func,
	input  logic [NUM_W-1:0]  number,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              chr_ready,
	output logic              chr_valid,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int HEXW       = HEX_DIGITS * 4;
	localparam int BIT_W      = $clog2(VALUE_WIDTH + 1);
	localparam int BCDW       = NUM_BCD * 4;

	logic [HEXW-1:0]   val_q;
	logic [BCDW-1:0]   bcd_q;
	logic [BCDW-1:0]   bcd_adj;
	logic [BIT_W-1:0]  bits_q;
	logic [CNT_W-1:0]  dig_q;
	logic              mode_q;
	logic              chr_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [3:0]        top_dig;
	logic [3:0]        top_nib;

	assign top_dig = bcd_q[BCDW-1 -: 4];
	assign top_nib = val_q[HEXW-1 -: 4];

	// add 3 to every digit of 5 or more
	always_comb begin
		for (int d = 0; d < NUM_BCD; d++) begin
			if (bcd_q[d*4 +: 4] >= 4'd5) begin
				bcd_adj[d*4 +: 4] = bcd_q[d*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[d*4 +: 4] = bcd_q[d*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q  <= HEXW'(number[VALUE_WIDTH-1:0]);
			bcd_q  <= '0;
			bits_q <= BIT_W'(VALUE_WIDTH);
			dig_q  <= func ? CNT_W'(HEX_DIGITS) : CNT_W'(NUM_BCD);
			mode_q <= func;
		end else if (cmd.dabble) begin
			bcd_q  <= {bcd_adj[BCDW-2:0], val_q[VALUE_WIDTH-1]};
			val_q  <= val_q << 1;
			bits_q <= bits_q - BIT_W'(1);
		end else if (cmd.shift) begin
			if (mode_q) begin
				val_q <= val_q << 4;
			end else begin
				bcd_q <= bcd_q << 4;
			end
			dig_q <= dig_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			chr_valid_q <= 1'b1;
		end else if (chr_ready) begin
			chr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.sel)
				SEL_ZERO:  char_q <= ASCII_ZERO;
				SEL_X:     char_q <= ASCII_X;
				SEL_DIGIT: char_q <= hex_char(mode_q ? top_nib : top_dig);
				default:   char_q <= ASCII_ZERO;
			endcase
			last_q <= cmd.last;
		end
	end

	assign sts.bits_done   = (bits_q == BIT_W'(1));
	assign sts.digits_last = (dig_q == CNT_W'(1));
	assign sts.top_zero    = (top_dig == 4'd0);
	assign sts.out_free    = !chr_valid_q || chr_ready;

	assign chr_valid = chr_valid_q;
	assign character = char_q;
	assign last      = last_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("character written over a pending one");
	a_dabble_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dabble |-> bits_q != '0)
		else $error("conversion step past the bit count");
	a_shift_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> dig_q != '0)
		else $error("digit shift past the digit count");

endmodule

### design/b2a_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2a_ctrl: formatter controller
// Sequences conversion, leading-zero skip, prefix and digit output.
// ----------------------------------------------------------------------------
module b2a_ctrl import b2a_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  logic func,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '{load: 1'b0, dabble: 1'b0, shift: 1'b0, emit: 1'b0,
			sel: SEL_DIGIT, last: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = func ? ST_PFX0 : ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
				if (sts.bits_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (sts.top_zero && !sts.digits_last) begin
					cmd.shift = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_PFX0: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_ZERO;
					state_d  = ST_PFX1;
				end
			end
			ST_PFX1: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_X;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.shift = 1'b1;
					cmd.sel   = SEL_DIGIT;
					cmd.last  = sts.digits_last;
					if (sts.digits_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### design/binary_to_ascii_number_formatter_unit.sv
`timescale 1ns / 1ps
// Sequence: decimal takes the request, VALUE_WIDTH double-dabble steps and the
//   leading-zero skip, then one digit per cycle while the output register is free.
// Hex takes the request, then "0x" and ceil(VALUE_WIDTH/4) digits, one per cycle while free.
// Requests: one at a time; a new request is taken only after the last digit of the
//   previous number is written to the output register, and characters wait for ready.
// Reset: arst_n clears the state machine and the output valid; data regs keep.
// ----------------------------------------------------------------------------
// binary_to_ascii_number_formatter_unit: number to ASCII text
// Renders an unsigned value as decimal (no leading zeros) or as "0x" plus
// lowercase hex digits, one character per output transfer, last flagged.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter_unit import b2a_pkg::*; #(
	parameter int VALUE_WIDTH = 64	// used bits of number, 4 to 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              req_valid,
	output logic              req_ready,
	input  logic              func,		// 0 decimal, 1 hex
	input  logic [NUM_W-1:0]  number,
	// character channel
	output logic              chr_valid,
	input  logic              chr_ready,
	output logic [CHAR_W-1:0] character,
	output logic              last
);

	// command and status between the controller and the datapath
	cmd_t cmd;
	sts_t sts;

	// The controller owns the request handshake; it takes a new request only
	// when idle, but the datapath's output register may still hold the final
	// character of the previous number while the next conversion runs.
	b2a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: the value register doubles as double-dabble source and as a
	// hex nibble shifter; the BCD chain shifts out its top digit per step.
	b2a_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.number    (number),
		.cmd       (cmd),
		.sts       (sts),
		.chr_ready (chr_ready),
		.chr_valid (chr_valid),
		.character (character),
		.last      (last)
	);

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_to_ascii_number_formatter_unit
// Drives decimal and hex requests with random gaps, predicts every output
// character, and compares each one, with its last flag, in order.
// ----------------------------------------------------------------------------
module tb;
	import b2a_pkg::*;

	localparam int VW          = 64;	// VALUE_WIDTH of the instance
	localparam int HEX_DIGITS  = (VW + 3) / 4;
	localparam int RAND_REQS   = 400;
	localparam int TAIL_CYCLES = 200;	// longer than one decimal conversion
	localparam logic [NUM_W-1:0] VALUE_MASK = {NUM_W{1'b1}} >> (NUM_W - VW);

	localparam logic FUNC_DEC = 1'b0;
	localparam logic FUNC_HEX = 1'b1;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	typedef struct {
		logic             func;
		logic [NUM_W-1:0] number;
		int               gap;		// idle cycles before valid goes up
		bit               drain;	// hold off until all text has come out
	} num_req_t;

	// DUT ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic              func = 1'b0;
	logic [NUM_W-1:0]  number = '0;
	logic              chr_valid;
	logic              chr_ready = 1'b0;
	logic [CHAR_W-1:0] character;
	logic              last;

	num_req_t   pending_reqs[$];
	text_char_t expected_chars[$];
	int         fail_count = 0;
	int         gap_count = 0;
	int         rx_stall_left = 0;
	int         rx_calm_left = 0;

	// predictor state, mirrors the formatter
	logic [NUM_W-1:0] fmt_shift = '0;
	logic [3:0]       fmt_bcd[NUM_BCD];
	logic [4:0]       fmt_count = '0;
	logic             fmt_mode = 1'b0;

	binary_to_ascii_number_formatter_unit #(
		.VALUE_WIDTH(VW)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.number    (number),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.character (character),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 10));
	endfunction

	// Expected text of one request, pushed in output order.
	function automatic void predict_text(input logic f, input logic [NUM_W-1:0] num);
		string            hex_set;
		logic [NUM_W-1:0] v;
		logic [CHAR_W-1:0] txt[$];
		logic [3:0]       nib;
		logic             cin;
		logic             cout;
		int               top;
		int               b;
		int               d;
		text_char_t       tc;
		hex_set = "0123456789abcdef";
		v = num & VALUE_MASK;
		fmt_mode = f;
		if (f == FUNC_HEX) begin
			fmt_shift = v;
			txt.push_back(ASCII_ZERO);
			txt.push_back(ASCII_X);
			for (d = HEX_DIGITS - 1; d >= 0; d--) begin
				nib = 4'((v >> (d * 4)) & 64'hf);
				txt.push_back(CHAR_W'(hex_set[nib]));
			end
		end else begin
			// shift-and-add-3, one input bit per step, MSB first
			for (d = 0; d < NUM_BCD; d++)
				fmt_bcd[d] = 4'd0;
			fmt_shift = v;
			for (b = 0; b < VW; b++) begin
				for (d = 0; d < NUM_BCD; d++)
					if (fmt_bcd[d] >= 4'd5)
						fmt_bcd[d] = fmt_bcd[d] + 4'd3;
				cin = fmt_shift[VW-1];
				fmt_shift = (fmt_shift << 1) & VALUE_MASK;
				for (d = 0; d < NUM_BCD; d++) begin
					cout = fmt_bcd[d][3];
					fmt_bcd[d] = {fmt_bcd[d][2:0], cin};
					cin = cout;
				end
			end
			// no leading zeros; zero value still gives one digit
			top = 0;
			for (d = NUM_BCD - 1; d > 0; d--) begin
				if (fmt_bcd[d] != 4'd0 && top == 0)
					top = d;
			end
			for (d = top; d >= 0; d--)
				txt.push_back(ASCII_ZERO + CHAR_W'(fmt_bcd[d] % 10));
		end
		for (d = 0; d < txt.size(); d++) begin
			tc.code = txt[d];
			tc.last = (d == txt.size() - 1);
			expected_chars.push_back(tc);
		end
		fmt_count = 5'(txt.size());
	endfunction

	task automatic queue_req(input logic f, input logic [NUM_W-1:0] num,
			input int gap, input bit drain);
		num_req_t r;
		r.func = f;
		r.number = num;
		r.gap = gap;
		r.drain = drain;
		pending_reqs.push_back(r);
	endtask

	// Request driver: one request in flight, gap counted before each valid.
	always @(posedge clk or negedge arst_n) begin : req_drive
		num_req_t head;
		if (!arst_n) begin
			req_valid <= 1'b0;
			func <= FUNC_DEC;
			number <= '0;
			gap_count <= 0;
		end else if (req_valid) begin
			if (req_ready) begin
				predict_text(func, number);
				req_valid <= 1'b0;
			end
		end else if (pending_reqs.size() > 0) begin
			head = pending_reqs[0];
			if (head.drain && expected_chars.size() != 0) begin
				gap_count <= 0;		// hold off until the text has drained
			end else if (gap_count < head.gap) begin
				gap_count <= gap_count + 1;
			end else begin
				void'(pending_reqs.pop_front());
				req_valid <= 1'b1;
				func <= head.func;
				number <= head.number;
				gap_count <= 0;
			end
		end
	end

	// Character monitor: checks each accepted character, then stalls a
	// random number of cycles, with calm stretches of no stall at all.
	always @(posedge clk or negedge arst_n) begin : chr_check
		text_char_t want;
		int         stall;
		if (!arst_n) begin
			chr_ready <= 1'b0;
			rx_stall_left <= 0;
		end else begin
			stall = rx_stall_left;
			if (chr_valid && chr_ready) begin
				if (expected_chars.size() == 0) begin
					$error("character: expected none, actual %h", character);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (character !== want.code) begin
						$error("character: expected %h, actual %h", want.code, character);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %b, actual %b", want.last, last);
						fail_count++;
					end
				end
				if (rx_calm_left > 0)
					rx_calm_left--;
				else if ($urandom_range(0, 49) == 0)
					rx_calm_left = $urandom_range(20, 80);
				stall = draw_wait(rx_calm_left > 0);
			end
			if (stall > 0) begin
				chr_ready <= 1'b0;
				rx_stall_left <= stall - 1;
			end else begin
				chr_ready <= 1'b1;
				rx_stall_left <= 0;
			end
		end
	end

	initial begin
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] p10;
		int               i;
		int               w;
		int               tx_calm_left;
		tx_calm_left = 0;
		for (i = 0; i < NUM_BCD; i++)
			fmt_bcd[i] = 4'd0;

		// directed: zero, digit-count boundaries, full range, hex extremes
		queue_req(FUNC_DEC, 64'd0, 0, 1'b0);
		queue_req(FUNC_DEC, 64'd1, 3, 1'b0);
		queue_req(FUNC_DEC, 64'd9, 0, 1'b0);
		queue_req(FUNC_DEC, 64'd10, 0, 1'b0);
		queue_req(FUNC_DEC, 64'd99, 5, 1'b0);
		queue_req(FUNC_DEC, 64'd100, 0, 1'b0);
		queue_req(FUNC_DEC, 64'd9999999999999999999, 0, 1'b0);
		queue_req(FUNC_DEC, 64'd10000000000000000000, 2, 1'b0);
		queue_req(FUNC_DEC, 64'hffff_ffff_ffff_ffff, 0, 1'b0);
		queue_req(FUNC_DEC, 64'h8000_0000_0000_0000, 0, 1'b0);
		queue_req(FUNC_DEC, 64'haaaa_aaaa_aaaa_aaaa, 1, 1'b0);
		queue_req(FUNC_DEC, 64'h5555_5555_5555_5555, 0, 1'b0);
		queue_req(FUNC_HEX, 64'd0, 0, 1'b0);
		queue_req(FUNC_HEX, 64'hffff_ffff_ffff_ffff, 0, 1'b0);
		queue_req(FUNC_HEX, 64'h0123_4567_89ab_cdef, 4, 1'b0);
		queue_req(FUNC_HEX, 64'hfedc_ba98_7654_3210, 0, 1'b0);
		queue_req(FUNC_HEX, 64'h8000_0000_0000_0001, 0, 1'b0);
		queue_req(FUNC_DEC, 64'd0, 0, 1'b1);	// decimal zero after a drain

		for (i = 0; i < RAND_REQS; i++) begin
			if (tx_calm_left > 0)
				tx_calm_left--;
			else if ($urandom_range(0, 39) == 0)
				tx_calm_left = $urandom_range(10, 40);
			case ($urandom_range(0, 3))
				0: num = {$urandom, $urandom};
				1: begin
					w = $urandom_range(1, 64);
					num = {$urandom, $urandom} >> (64 - w);
				end
				2: begin
					// around powers of ten: digit-count edges
					p10 = 64'd1;
					repeat ($urandom_range(0, 19)) p10 = p10 * 64'd10;
					num = p10 - 64'($urandom_range(0, 1));
				end
				default: num = 64'($urandom_range(0, 1000));
			endcase
			queue_req(logic'($urandom_range(0, 1)), num, draw_wait(tx_calm_left > 0),
				i == 0 || $urandom_range(0, 49) == 0);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_chars.size() != 0) begin
			$error("character: %0d expected, actual none", expected_chars.size());
			fail_count++;
		end

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#8_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### binary_to_ascii_number_formatter_unit.f
design/b2a_pkg.sv
design/b2a_dp.sv
design/b2a_ctrl.sv
design/binary_to_ascii_number_formatter_unit.sv
bench/tb.sv
